/* design/assert_macros.svh */
// Assertion macros used by the top-level design file; clk and rst come from the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/lzd_pkg.sv */
// Types and constants of the LZ77 token decompressor.
`timescale 1ns / 1ps
package lzd_pkg;

  localparam int DEF_WINDOW_SIZE = 4096;
  localparam int DEF_SIZE_BITS   = 24;

  // Token format: 12-bit displacement field, 4-bit length field.
  localparam int DISP_BITS = 12;
  localparam int LEN_BITS  = 5;

  localparam logic [2:0]          HEADER_LEN = 3'd4;
  localparam logic [3:0]          FLAG_COUNT = 4'd8;
  localparam logic [LEN_BITS-1:0] LEN_BIAS   = 5'd3;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_SIZE  = 2'd1,
    STAT_TRUNC = 2'd2,
    STAT_REF   = 2'd3
  } lzd_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_STATUS
  } lzd_state_t;

endpackage

/* design/lzd_in_if.sv */
// Input channel: one compressed byte per beat.
`timescale 1ns / 1ps
interface lzd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

/* design/lzd_out_if.sv */
// Output channel: decompressed bytes and the per-stream status beat.
`timescale 1ns / 1ps
interface lzd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic [1:0] status;
  logic       stream_done;

  modport source (output valid, output out_byte, output byte_valid, output run_last,
                  output status, output stream_done, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input run_last,
                input status, input stream_done, output ready);
endinterface

/* design/lzd_cfg_if.sv */
// Configuration channel: writes the expected decompressed size.
`timescale 1ns / 1ps
interface lzd_cfg_if #(
  parameter int SIZE_BITS = lzd_pkg::DEF_SIZE_BITS
);
  logic                 valid;
  logic                 ready;
  logic [SIZE_BITS-1:0] out_size;

  modport source (output valid, output out_size, input ready);
  modport sink (input valid, input out_size, output ready);
endinterface

/* design/lzd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lzd_pkg::DEF_WINDOW_SIZE,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/lzd_ctrl.sv */
// Stream parser and copy sequencer around the history RAM.
`timescale 1ns / 1ps
module lzd_ctrl #(
  parameter int WINDOW_SIZE = lzd_pkg::DEF_WINDOW_SIZE,
  parameter int SIZE_BITS   = lzd_pkg::DEF_SIZE_BITS,
  localparam int AW = $clog2(WINDOW_SIZE)
) (
  input  logic                 clk,
  input  logic                 rst,
  lzd_in_if.sink               din,
  lzd_out_if.source            dout,
  input  logic [SIZE_BITS-1:0] out_size,
  output logic                 ram_we,
  output logic [AW-1:0]        ram_waddr,
  output logic [7:0]           ram_wdata,
  output logic                 ram_re,
  output logic [AW-1:0]        ram_raddr,
  input  logic [7:0]           ram_rdata
);

  localparam int DW = lzd_pkg::DISP_BITS + 1;
  localparam int LW = lzd_pkg::LEN_BITS;

  lzd_pkg::lzd_state_t  state, state_next;
  logic [2:0]           header_left, header_left_next;
  logic [7:0]           flag_bits, flag_bits_next;
  logic [3:0]           bits_left, bits_left_next;
  logic                 token_pending, token_pending_next;
  logic [7:0]           token_high, token_high_next;
  logic [SIZE_BITS-1:0] out_count, out_count_next;
  lzd_pkg::lzd_status_t error_code, error_code_next;
  logic [LW-1:0]        copy_left, copy_left_next;
  logic [AW-1:0]        rd_ptr, rd_ptr_next;
  logic                 item_last, item_last_next;

  // Output register.
  logic                 o_valid;
  logic [7:0]           o_byte;
  logic                 o_bvalid;
  logic                 o_run_last;
  logic [1:0]           o_status;
  logic                 o_done;

  logic                 out_free;
  logic                 accept;
  logic                 load;
  logic [7:0]           ld_byte;
  logic                 ld_bvalid;
  logic                 ld_run_last;
  lzd_pkg::lzd_status_t ld_status;
  logic                 ld_done;
  logic [15:0]          tok;
  logic [DW-1:0]        disp;
  logic [LW-1:0]        len;
  logic [SIZE_BITS:0]   sum_len;
  logic [SIZE_BITS:0]   sum_one;

  assign out_free         = !o_valid || dout.ready;
  assign din.ready        = (state == lzd_pkg::ST_IDLE) && out_free;
  assign accept           = din.valid && din.ready;
  assign dout.valid       = o_valid;
  assign dout.out_byte    = o_byte;
  assign dout.byte_valid  = o_bvalid;
  assign dout.run_last    = o_run_last;
  assign dout.status      = o_status;
  assign dout.stream_done = o_done;

  assign tok     = {token_high, din.in_byte};
  assign disp    = {1'b0, tok[lzd_pkg::DISP_BITS-1:0]} + DW'(1);
  assign len     = {1'b0, tok[15:lzd_pkg::DISP_BITS]} + lzd_pkg::LEN_BIAS;
  assign sum_len = {1'b0, out_count} + (SIZE_BITS + 1)'(len);
  assign sum_one = {1'b0, out_count} + (SIZE_BITS + 1)'(1);

  always_comb begin
    state_next         = state;
    header_left_next   = header_left;
    flag_bits_next     = flag_bits;
    bits_left_next     = bits_left;
    token_pending_next = token_pending;
    token_high_next    = token_high;
    out_count_next     = out_count;
    error_code_next    = error_code;
    copy_left_next     = copy_left;
    rd_ptr_next        = rd_ptr;
    item_last_next     = item_last;
    load               = 1'b0;
    ld_byte            = din.in_byte;
    ld_bvalid          = 1'b0;
    ld_run_last        = 1'b0;
    ld_status          = lzd_pkg::STAT_OK;
    ld_done            = 1'b0;
    ram_we             = 1'b0;
    ram_waddr          = out_count[AW-1:0];
    ram_wdata          = din.in_byte;
    ram_re             = 1'b0;
    ram_raddr          = rd_ptr;

    case (state)
      lzd_pkg::ST_IDLE: begin
        if (accept) begin
          item_last_next = din.in_last;
          if (error_code != lzd_pkg::STAT_OK) begin
            // drop bytes of a failed stream
          end else if (header_left != 3'd0) begin
            header_left_next = header_left - 3'd1;
          end else if (token_pending) begin
            token_pending_next = 1'b0;
            if (SIZE_BITS'(disp) > out_count) begin
              error_code_next = lzd_pkg::STAT_REF;
            end else if (sum_len > {1'b0, out_size}) begin
              error_code_next = lzd_pkg::STAT_SIZE;
            end else begin
              copy_left_next = len;
              rd_ptr_next    = out_count[AW-1:0] - AW'(disp);
              state_next     = lzd_pkg::ST_READ;
            end
          end else if (bits_left == 4'd0) begin
            flag_bits_next = din.in_byte;
            bits_left_next = lzd_pkg::FLAG_COUNT;
          end else begin
            flag_bits_next = {flag_bits[6:0], 1'b0};
            bits_left_next = bits_left - 4'd1;
            if (flag_bits[7]) begin
              token_high_next    = din.in_byte;
              token_pending_next = 1'b1;
            end else if (sum_one > {1'b0, out_size}) begin
              error_code_next = lzd_pkg::STAT_SIZE;
            end else begin
              load           = 1'b1;
              ld_bvalid      = 1'b1;
              ld_run_last    = !din.in_last;
              ram_we         = 1'b1;
              out_count_next = out_count + SIZE_BITS'(1);
            end
          end
          if (din.in_last && state_next == lzd_pkg::ST_IDLE) begin
            state_next = lzd_pkg::ST_STATUS;
          end
        end
      end
      lzd_pkg::ST_READ: begin
        ram_re     = 1'b1;
        state_next = lzd_pkg::ST_WRITE;
      end
      lzd_pkg::ST_WRITE: begin
        // read data holds in the RAM register until the output slot frees
        if (out_free) begin
          load           = 1'b1;
          ld_byte        = ram_rdata;
          ld_bvalid      = 1'b1;
          ld_run_last    = (copy_left == LW'(1)) && !item_last;
          ram_we         = 1'b1;
          ram_wdata      = ram_rdata;
          out_count_next = out_count + SIZE_BITS'(1);
          rd_ptr_next    = rd_ptr + AW'(1);
          copy_left_next = copy_left - LW'(1);
          if (copy_left == LW'(1)) begin
            state_next = item_last ? lzd_pkg::ST_STATUS : lzd_pkg::ST_IDLE;
          end else begin
            state_next = lzd_pkg::ST_READ;
          end
        end
      end
      lzd_pkg::ST_STATUS: begin
        if (out_free) begin
          load        = 1'b1;
          ld_byte     = 8'd0;
          ld_run_last = 1'b1;
          ld_done     = 1'b1;
          if (error_code != lzd_pkg::STAT_OK) begin
            ld_status = error_code;
          end else if (token_pending) begin
            ld_status = lzd_pkg::STAT_TRUNC;
          end else if (out_count != out_size) begin
            ld_status = lzd_pkg::STAT_SIZE;
          end else begin
            ld_status = lzd_pkg::STAT_OK;
          end
          // re-arm for the next stream; history is kept
          header_left_next   = lzd_pkg::HEADER_LEN;
          flag_bits_next     = 8'd0;
          bits_left_next     = 4'd0;
          token_pending_next = 1'b0;
          token_high_next    = 8'd0;
          out_count_next     = '0;
          error_code_next    = lzd_pkg::STAT_OK;
          state_next         = lzd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lzd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lzd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_left   <= lzd_pkg::HEADER_LEN;
      flag_bits     <= 8'd0;
      bits_left     <= 4'd0;
      token_pending <= 1'b0;
      token_high    <= 8'd0;
      out_count     <= '0;
      error_code    <= lzd_pkg::STAT_OK;
      copy_left     <= '0;
      item_last     <= 1'b0;
      o_valid       <= 1'b0;
    end else begin
      header_left   <= header_left_next;
      flag_bits     <= flag_bits_next;
      bits_left     <= bits_left_next;
      token_pending <= token_pending_next;
      token_high    <= token_high_next;
      out_count     <= out_count_next;
      error_code    <= error_code_next;
      copy_left     <= copy_left_next;
      item_last     <= item_last_next;
      if (load) begin
        o_valid <= 1'b1;
      end else if (dout.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr <= rd_ptr_next;
    if (load) begin
      o_byte     <= ld_byte;
      o_bvalid   <= ld_bvalid;
      o_run_last <= ld_run_last;
      o_status   <= ld_status;
      o_done     <= ld_done;
    end
  end

endmodule

/* design/lz77_token_decompressor.sv */
// LZ77 token decompressor: size register, history RAM and parser/copy sequencer.
//
// Usage:
//   din  - compressed stream, one byte per beat; in_last marks the final byte.
//   dout - one beat per decompressed byte (byte_valid=1), then after in_last one
//          status beat (byte_valid=0, stream_done=1, status code). run_last marks
//          the last beat caused by an input byte.
//   cfg  - writes the expected output size; write it only while the block is idle.
// Timing: header, flag and literal bytes are accepted in the idle state; a literal
//   shows on dout in the cycle after acceptance. A token's second byte starts a copy
//   in which each output byte takes a history RAM read, then write-back and emit;
//   the input stays not ready until the copy ends. The status beat follows the last
//   byte's data.
// Reset: parser state returns to the start of a stream, out_size clears to zero.
//   The 4096-byte history is not cleared; a copy only reads bytes written earlier
//   in the same stream.
// Stall: while dout is not taken the output register holds its beat and din
//   stays not ready; no beat is lost or repeated.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lz77_token_decompressor #(
  parameter int WINDOW_SIZE = lzd_pkg::DEF_WINDOW_SIZE,
  parameter int SIZE_BITS   = lzd_pkg::DEF_SIZE_BITS
) (
  input  logic      clk,
  input  logic      rst,
  lzd_in_if.sink    din,
  lzd_out_if.source dout,
  lzd_cfg_if.sink   cfg
);

  localparam int AW = $clog2(WINDOW_SIZE);

  logic [SIZE_BITS-1:0] out_size;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [7:0]           ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [7:0]           ram_rdata;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_size <= '0;
    end else if (cfg.valid) begin
      out_size <= SIZE_BITS'(cfg.out_size);
    end
  end

  lzd_ctrl #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .SIZE_BITS   (SIZE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .din       (din),
    .dout      (dout),
    .out_size  (out_size),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  lzd_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_SIZE)
  ) u_history (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  `ASSERT_NEXT(a_write_emits, ram_we, dout.valid && dout.byte_valid, "history write without data beat")
  `ASSERT_NEXT(a_copy_holds_input, ram_re, !din.ready, "input taken during copy")
  `ASSERT_IMPL(a_no_rw_overlap, ram_re, !ram_we, "history read and write in one cycle")
  `ASSERT_IMPL(a_done_beat, dout.valid && dout.stream_done, dout.run_last && !dout.byte_valid, "bad status beat")

endmodule
